// File: src/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// Holds the transfer payload structs, result codes and the controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps

package bba_pkg;

	// Fixed field widths
	localparam int BLK_W = 10;
	localparam int CNT_W = 11;

	// Largest value that the count register can express
	localparam int CNT_MAX = (1 << CNT_W) - 1;

	// Count register value after reset
	localparam logic [CNT_W-1:0] TOTAL_RESET = 11'd1024;

	// Result codes
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_FULL        = 2'd1,
		ST_DOUBLE_FREE = 2'd2,
		ST_RANGE       = 2'd3
	} status_t;

	// Request kinds
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [BLK_W-1:0] block_in;
	} bba_in_t;

	typedef struct packed {
		logic [BLK_W-1:0] block_out;
		status_t          status;
	} bba_out_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clear_step;
		logic accept;
		logic scan_step;
		logic f_div;
		logic f_rd;
		logic f_chk;
		logic out_load;
	} bba_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_last;
		logic scan_done;
	} bba_sts_t;

endpackage

// File: src/bba_ctrl.sv
// Controller state machine of the bitmap block allocator.
// Sequences the clearing pass, the allocate scan, the free check and the result handoff.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output bba_pkg::bba_cmd_t cmd,
	input  bba_pkg::bba_sts_t sts
);
	import bba_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_ASCAN = 7'b0000100,
		S_FDIV  = 7'b0001000,
		S_FRD   = 7'b0010000,
		S_FCHK  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = (in_cmd == CMD_FREE) ? S_FDIV : S_ASCAN;
				end
			end
			S_ASCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_d = S_DONE;
				end
			end
			S_FDIV: begin
				cmd.f_div = 1'b1;
				state_d   = S_FRD;
			end
			S_FRD: begin
				cmd.f_rd = 1'b1;
				state_d  = S_FCHK;
			end
			S_FCHK: begin
				cmd.f_chk = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid: set on load, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// One request at a time: busy right after an accepted transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("bba_ctrl: ready again right after accept");

	// A finished result is presented on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("bba_ctrl: loaded result not presented");

	// No bitmap activity while waiting for a request
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
			!(cmd.clear_step || cmd.scan_step || cmd.f_rd || cmd.f_chk))
		else $error("bba_ctrl: bitmap command while idle");

	// The clearing pass ends before the first request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !$past(cmd.clear_step) || $past(sts.clear_last))
		else $error("bba_ctrl: request accepted during clearing pass");

endmodule

// File: src/bba_dpath.sv
// Datapath of the bitmap block allocator: bitmap memory, scan pipeline, free check.
// Holds the count register and the result and output registers.
// Depends on bba_pkg; driven by bba_ctrl.
`timescale 1ns / 1ps

module bba_dpath #(
	parameter int MAX_BLOCKS = 1024,
	parameter int WORD_BITS  = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bba_pkg::CNT_W-1:0]        cfg_wdata,
	input  bba_pkg::bba_in_t                 in_data,
	output bba_pkg::bba_out_t                out_data,
	input  bba_pkg::bba_cmd_t                cmd,
	output bba_pkg::bba_sts_t                sts
);
	import bba_pkg::*;

	localparam int NUM_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int LAST_WORD  = NUM_WORDS - 1;
	localparam int BP_W       = $clog2(WORD_BITS);
	localparam int BASE_W     = $clog2(CNT_MAX + WORD_BITS + 1);
	// Word index of a block number: multiply by a rounded-up reciprocal
	localparam int DIV_SHIFT  = BLK_W + BP_W;
	localparam int DIV_RECIP  = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
	localparam int RECIP_W    = $clog2(DIV_RECIP + 1);
	localparam int PROD_W     = BLK_W + RECIP_W;

	// Lowest set bit of a word
	function automatic logic [BP_W-1:0] low_index(input logic [WORD_BITS-1:0] v);
		logic [WORD_BITS-1:0] iso;
		logic [BP_W-1:0]      idx;
		iso = v & (~v + WORD_BITS'(1));
		idx = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (iso[j]) begin
				idx = idx | BP_W'(j);
			end
		end
		return idx;
	endfunction

	logic [WORD_BITS-1:0] mem [NUM_WORDS];

	logic [CNT_W-1:0]     total_q;
	logic [CNT_W-1:0]     eff_count;
	logic [BASE_W-1:0]    cnt_ext;
	logic [BLK_W-1:0]     blk_q;
	logic [AW-1:0]        widx_q;
	logic [BP_W-1:0]      bitpos_q;
	logic [PROD_W-1:0]    div_prod;

	logic [AW-1:0]        scan_addr_q;
	logic [BASE_W-1:0]    scan_base_q;
	logic                 scan_end_q;
	logic                 valid_s1;
	logic [AW-1:0]        addr_s1;
	logic [BASE_W-1:0]    base_s1;
	logic [WORD_BITS-1:0] rdata_s1;

	logic [BASE_W-1:0]    rem;
	logic [WORD_BITS-1:0] avail;
	logic                 found;
	logic                 last;
	logic [BP_W-1:0]      pos;
	logic [BASE_W:0]      next_base;
	logic [BASE_W-1:0]    alloc_blk;
	logic                 in_range;
	logic                 hit_bit;

	logic                 we;
	logic [AW-1:0]        wa;
	logic [WORD_BITS-1:0] wd;
	logic                 re;
	logic [AW-1:0]        ra;

	bba_out_t             res_q;
	bba_out_t             out_q;

	// Effective count saturates at the bitmap size
	assign eff_count = (32'(total_q) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : total_q;
	assign cnt_ext   = BASE_W'(eff_count);

	// Scan word evaluation: only bits below the count are candidates
	always_comb begin
		rem = (cnt_ext > base_s1) ? BASE_W'(cnt_ext - base_s1) : '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			avail[j] = !rdata_s1[j] && (BASE_W'(j) < rem);
		end
	end

	assign found     = |avail;
	assign pos       = low_index(avail);
	assign next_base = {1'b0, base_s1} + (BASE_W + 1)'(WORD_BITS);
	assign last      = (next_base >= {1'b0, cnt_ext});
	assign alloc_blk = BASE_W'(base_s1 + BASE_W'(pos));

	// Free check
	assign in_range  = ({1'b0, blk_q} < eff_count);
	assign hit_bit   = rdata_s1[bitpos_q];
	assign div_prod  = PROD_W'(blk_q) * PROD_W'(DIV_RECIP);

	assign sts.clear_last = (scan_addr_q == AW'(LAST_WORD));
	assign sts.scan_done  = valid_s1 && (found || last);

	// Memory port selection
	always_comb begin
		we = 1'b0;
		wa = scan_addr_q;
		wd = '0;
		re = 1'b0;
		ra = scan_addr_q;
		if (cmd.clear_step) begin
			we = 1'b1;
		end else if (cmd.scan_step && valid_s1 && found) begin
			we = 1'b1;
			wa = addr_s1;
			wd = rdata_s1 | (WORD_BITS'(1) << pos);
		end else if (cmd.f_chk && in_range && hit_bit) begin
			we = 1'b1;
			wa = widx_q;
			wd = rdata_s1 & ~(WORD_BITS'(1) << bitpos_q);
		end
		if (cmd.scan_step && !scan_end_q) begin
			re = 1'b1;
		end
		if (cmd.f_rd && in_range) begin
			re = 1'b1;
			ra = widx_q;
		end
	end

	// Bitmap memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rdata_s1 <= mem[ra];
		end
	end

	// Count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
		end else if (cfg_we) begin
			total_q <= cfg_wdata;
		end
	end

	// Scan address, clearing sweep and read-valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			scan_base_q <= '0;
			scan_end_q  <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			valid_s1 <= 1'b0;
			if (cmd.clear_step || cmd.accept) begin
				scan_addr_q <= cmd.accept ? '0 : AW'(scan_addr_q + 1'b1);
				scan_base_q <= '0;
				scan_end_q  <= 1'b0;
			end else if (cmd.scan_step && !scan_end_q) begin
				valid_s1    <= 1'b1;
				scan_addr_q <= AW'(scan_addr_q + 1'b1);
				scan_base_q <= BASE_W'(scan_base_q + BASE_W'(WORD_BITS));
				scan_end_q  <= (scan_addr_q == AW'(LAST_WORD));
			end
		end
	end

	// Pipeline word tag alongside the read
	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			addr_s1 <= scan_addr_q;
			base_s1 <= scan_base_q;
		end
	end

	// Request payload and free word/bit split
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			blk_q <= in_data.block_in;
		end
		if (cmd.f_div) begin
			widx_q <= AW'(div_prod >> DIV_SHIFT);
		end
		if (cmd.f_rd) begin
			bitpos_q <= BP_W'(blk_q - BLK_W'(widx_q * WORD_BITS));
		end
	end

	// Result capture and output register
	always_ff @(posedge clk) begin
		if (cmd.scan_step && sts.scan_done) begin
			res_q.block_out <= found ? alloc_blk[BLK_W-1:0] : '0;
			res_q.status    <= found ? ST_OK : ST_FULL;
		end else if (cmd.f_chk) begin
			res_q.block_out <= blk_q;
			if (!in_range) begin
				res_q.status <= ST_RANGE;
			end else if (!hit_bit) begin
				res_q.status <= ST_DOUBLE_FREE;
			end else begin
				res_q.status <= ST_OK;
			end
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign out_data = out_q;

endmodule

// File: src/bitmap_block_allocator.sv
// First-fit bitmap block allocator. One in-use bit per block, WORD_BITS bits to a
// memory word. An allocate request scans the words from block 0 upward one word per
// cycle through the single read port of the bitmap memory and takes the lowest free
// block below min(total_blocks, MAX_BLOCKS), examining at most ceil(MAX_BLOCKS / WORD_BITS)
// words. A free request steps through word index, read, check and write-back. One
// request is in work at a time; the next one may be accepted while the previous result
// still waits in the output register. After reset a clearing pass writes every bitmap
// word to zero, during which no request is accepted; the count register can be written
// at any time the block is idle.
// Depends on bba_pkg, bba_ctrl, bba_dpath.
`timescale 1ns / 1ps

module bitmap_block_allocator #(
	parameter int MAX_BLOCKS = 1024,
	parameter int WORD_BITS  = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bba_pkg::CNT_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bba_pkg::bba_in_t          in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bba_pkg::bba_out_t         out_data
);
	import bba_pkg::*;

	bba_cmd_t cmd;
	bba_sts_t sts;

	// Sequencing
	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_cmd    (in_data.cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Bitmap and result datapath
	bba_dpath #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.WORD_BITS  (WORD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
